// File: rtl/bfr_pkg.sv
`default_nettype none

package bfr_pkg;

   localparam int VALUE_BITS    = 64;
   localparam int VBR_MAX_WIDTH = 32;
   localparam int ALIGN_BITS    = 32;

   typedef logic [2:0]            command_type;
   typedef logic [6:0]            width_type;
   typedef logic [63:0]           word_type;
   typedef logic [3:0]            bytes_type;
   typedef logic [VALUE_BITS-1:0] value_type;
   typedef logic [2:0]            status_type;
   typedef logic [6:0]            count_type;
   typedef logic [3:0]            op_type;

   localparam command_type CMD_WORD  = 3'd0;
   localparam command_type CMD_FIXED = 3'd1;
   localparam command_type CMD_VBR32 = 3'd2;
   localparam command_type CMD_VBR64 = 3'd3;
   localparam command_type CMD_ALIGN = 3'd4;
   localparam command_type NO_REQ    = 3'd0;

   localparam status_type ST_OK         = 3'd0;
   localparam status_type ST_SHORT      = 3'd1;
   localparam status_type ST_WIDTH      = 3'd2;
   localparam status_type ST_UNEXPECTED = 3'd3;
   localparam status_type ST_PAST_END   = 3'd4;

   localparam op_type OP_NONE    = 4'd0;
   localparam op_type OP_LOAD    = 4'd1;
   localparam op_type OP_REJECT  = 4'd2;
   localparam op_type OP_SHORT   = 4'd3;
   localparam op_type OP_COMBINE = 4'd4;
   localparam op_type OP_ALIGN   = 4'd5;
   localparam op_type OP_START   = 4'd6;
   localparam op_type OP_TAKE    = 4'd7;
   localparam op_type OP_ACC     = 4'd8;

   typedef struct packed {
      op_type     op;
      status_type status;
      logic       load_out;
   } dp_cmd_type;

   typedef struct packed {
      logic is_word;
      logic is_bad_cmd;
      logic is_align;
      logic pending;
      logic ended;
      logic width_ok;
      logic short_word;
      logic enough;
      logic last_piece;
      logic out_free;
   } dp_stat_type;

   function automatic value_type mask64(input width_type n);
      return ~(~value_type'(0) << n);
   endfunction

endpackage

`default_nettype wire

// File: rtl/bfr_req_if.sv
`default_nettype none

interface bfr_req_if;
   logic                 valid;
   logic                 ready;
   bfr_pkg::command_type command;
   bfr_pkg::width_type   field_width;
   bfr_pkg::word_type    stream_word;
   bfr_pkg::bytes_type   byte_count;

   modport source (output valid, command, field_width, stream_word, byte_count,
                   input ready);
   modport sink (input valid, command, field_width, stream_word, byte_count,
                 output ready);
endinterface

`default_nettype wire

// File: rtl/bfr_rsp_if.sv
`default_nettype none

interface bfr_rsp_if;
   logic                valid;
   logic                ready;
   bfr_pkg::value_type  value;
   bfr_pkg::status_type status;
   bfr_pkg::count_type  bits_held;

   modport source (output valid, value, status, bits_held, input ready);
   modport sink (input valid, value, status, bits_held, output ready);
endinterface

`default_nettype wire

// File: rtl/bfr_datapath.sv
`default_nettype none

module bfr_datapath #(
   parameter int WORD_BITS = 64
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire bfr_pkg::dp_cmd_type  cmd,
   output bfr_pkg::dp_stat_type      stat,
   input  wire bfr_pkg::command_type req_command,
   input  wire bfr_pkg::width_type   req_field_width,
   input  wire bfr_pkg::word_type    req_stream_word,
   input  wire bfr_pkg::bytes_type   req_byte_count,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output bfr_pkg::value_type        rsp_value,
   output bfr_pkg::status_type       rsp_status,
   output bfr_pkg::count_type        rsp_bits_held
);
   import bfr_pkg::*;

   localparam int MAX_BYTES = WORD_BITS / 8;

   typedef logic [WORD_BITS-1:0] held_type;

   function automatic held_type hmask(input width_type n);
      return ~(~held_type'(0) << n);
   endfunction

   // latched word
   command_type in_cmd_ff, in_cmd_in;
   width_type   in_width_ff, in_width_in;
   word_type    in_word_ff, in_word_in;
   bytes_type   in_bytes_ff, in_bytes_in;

   // reader state
   held_type    held_ff, held_in;
   count_type   cnt_ff, cnt_in;
   command_type pend_kind_ff, pend_kind_in;
   width_type   pend_w_ff, pend_w_in;
   value_type   part_ff, part_in;
   count_type   pos_ff, pos_in;
   logic        end_ff, end_in;

   value_type   piece_ff, piece_in;
   value_type   res_value_ff, res_value_in;
   status_type  res_status_ff, res_status_in;

   logic        rsp_valid_ff, rsp_valid_in;
   value_type   rsp_value_ff, rsp_value_in;
   status_type  rsp_status_ff, rsp_status_in;
   count_type   rsp_bits_ff, rsp_bits_in;

   bytes_type   bytes_eff;
   count_type   nbits;
   count_type   need;
   held_type    new_bits;
   held_type    take_bits;
   value_type   combined;
   width_type   pw_m1;
   value_type   vbr_data;
   value_type   part_new;
   logic [7:0]  pos_sum;
   count_type   pos_new;
   logic        is_vbr;
   logic        width_ok;

   assign bytes_eff = (in_bytes_ff > bytes_type'(MAX_BYTES)) ? bytes_type'(MAX_BYTES)
                                                             : in_bytes_ff;
   assign nbits     = {bytes_eff, 3'b000};
   assign need      = pend_w_ff - cnt_ff;
   assign new_bits  = in_word_ff[WORD_BITS-1:0] & hmask(nbits);
   assign take_bits = new_bits & hmask(need);
   assign combined  = VALUE_BITS'(held_ff) | (VALUE_BITS'(take_bits) << cnt_ff);

   assign pw_m1     = pend_w_ff - width_type'(1);
   assign vbr_data  = piece_ff & mask64(pw_m1);
   assign part_new  = part_ff | (vbr_data << pos_ff);
   assign pos_sum   = {1'b0, pos_ff} + {1'b0, pw_m1};
   assign pos_new   = (pos_sum > 8'(VALUE_BITS)) ? count_type'(VALUE_BITS) : pos_sum[6:0];

   assign is_vbr    = in_cmd_ff inside {CMD_VBR32, CMD_VBR64};
   assign width_ok  = is_vbr ? (in_width_ff >= width_type'(2) &&
                                in_width_ff <= width_type'(VBR_MAX_WIDTH))
                             : (in_width_ff != '0 && in_width_ff <= width_type'(WORD_BITS));

   always_comb begin
      stat.is_word    = (in_cmd_ff == CMD_WORD);
      stat.is_bad_cmd = (in_cmd_ff > CMD_ALIGN);
      stat.is_align   = (in_cmd_ff == CMD_ALIGN);
      stat.pending    = (pend_kind_ff != NO_REQ);
      stat.ended      = end_ff;
      stat.width_ok   = width_ok;
      stat.short_word = (nbits < need);
      stat.enough     = (cnt_ff >= pend_w_ff);
      stat.last_piece = (pend_kind_ff == CMD_FIXED) || !piece_ff[pw_m1[5:0]];
      stat.out_free   = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      in_cmd_in     = in_cmd_ff;
      in_width_in   = in_width_ff;
      in_word_in    = in_word_ff;
      in_bytes_in   = in_bytes_ff;
      held_in       = held_ff;
      cnt_in        = cnt_ff;
      pend_kind_in  = pend_kind_ff;
      pend_w_in     = pend_w_ff;
      part_in       = part_ff;
      pos_in        = pos_ff;
      end_in        = end_ff;
      piece_in      = piece_ff;
      res_value_in  = res_value_ff;
      res_status_in = res_status_ff;
      case (cmd.op)
         OP_LOAD: begin
            in_cmd_in   = req_command;
            in_width_in = req_field_width;
            in_word_in  = req_stream_word;
            in_bytes_in = req_byte_count;
         end
         OP_REJECT: begin
            res_value_in  = '0;
            res_status_in = cmd.status;
         end
         OP_SHORT: begin
            held_in       = new_bits;
            cnt_in        = nbits;
            pend_kind_in  = NO_REQ;
            pend_w_in     = '0;
            part_in       = '0;
            pos_in        = '0;
            end_in        = 1'b1;
            res_value_in  = '0;
            res_status_in = ST_SHORT;
         end
         OP_COMBINE: begin
            piece_in = combined;
            held_in  = new_bits >> need;
            cnt_in   = nbits - need;
         end
         OP_ALIGN: begin
            if (WORD_BITS > ALIGN_BITS && cnt_ff >= count_type'(ALIGN_BITS)) begin
               held_in = held_ff >> (cnt_ff - count_type'(ALIGN_BITS));
               cnt_in  = count_type'(ALIGN_BITS);
            end else begin
               held_in = '0;
               cnt_in  = '0;
            end
            res_value_in  = '0;
            res_status_in = ST_OK;
         end
         OP_START: begin
            pend_kind_in = in_cmd_ff;
            pend_w_in    = in_width_ff;
            part_in      = '0;
            pos_in       = '0;
         end
         OP_TAKE: begin
            piece_in = VALUE_BITS'(held_ff & hmask(pend_w_ff));
            held_in  = held_ff >> pend_w_ff;
            cnt_in   = cnt_ff - pend_w_ff;
         end
         OP_ACC: begin
            if (pend_kind_ff == CMD_FIXED) begin
               res_value_in  = piece_ff;
               res_status_in = ST_OK;
               pend_kind_in  = NO_REQ;
               pend_w_in     = '0;
            end else if (!piece_ff[pw_m1[5:0]]) begin
               res_value_in  = (pend_kind_ff == CMD_VBR32) ? {32'b0, part_new[31:0]}
                                                           : part_new;
               res_status_in = ST_OK;
               pend_kind_in  = NO_REQ;
               pend_w_in     = '0;
               part_in       = '0;
               pos_in        = '0;
            end else begin
               part_in = part_new;
               pos_in  = pos_new;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_bits_in   = rsp_bits_ff;
      if (cmd.load_out) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = res_value_ff;
         rsp_status_in = res_status_ff;
         rsp_bits_in   = cnt_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff      <= '0;
         cnt_ff       <= '0;
         pend_kind_ff <= NO_REQ;
         pend_w_ff    <= '0;
         part_ff      <= '0;
         pos_ff       <= '0;
         end_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         held_ff      <= held_in;
         cnt_ff       <= cnt_in;
         pend_kind_ff <= pend_kind_in;
         pend_w_ff    <= pend_w_in;
         part_ff      <= part_in;
         pos_ff       <= pos_in;
         end_ff       <= end_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_cmd_ff     <= in_cmd_in;
      in_width_ff   <= in_width_in;
      in_word_ff    <= in_word_in;
      in_bytes_ff   <= in_bytes_in;
      piece_ff      <= piece_in;
      res_value_ff  <= res_value_in;
      res_status_ff <= res_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_bits_ff   <= rsp_bits_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value     = rsp_value_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_bits_held = rsp_bits_ff;

`ifndef SYNTHESIS
   a_held_clean: assert property (@(posedge clock) disable iff (reset)
      (held_ff & ~hmask(cnt_ff)) == '0)
      else $error("held word has bits above the held count");
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= count_type'(WORD_BITS))
      else $error("held count beyond word size");
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= count_type'(VALUE_BITS))
      else $error("vbr bit position beyond value size");
   a_end_sticky: assert property (@(posedge clock) disable iff (reset)
      ($past(end_ff) && !$past(reset)) |-> end_ff)
      else $error("end of stream flag cleared without reset");
`endif

endmodule

`default_nettype wire

// File: rtl/bfr_controller.sv
`default_nettype none

module bfr_controller (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire bfr_pkg::dp_stat_type stat,
   output bfr_pkg::dp_cmd_type       cmd
);
   import bfr_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECODE = 3'd1;
   localparam logic [2:0] S_TAKE   = 3'd2;
   localparam logic [2:0] S_ACC    = 3'd3;
   localparam logic [2:0] S_EMIT   = 3'd4;

   logic [2:0] state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE) && !reset;

   always_comb begin
      state_in     = state_ff;
      cmd.op       = OP_NONE;
      cmd.status   = ST_OK;
      cmd.load_out = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_EMIT;
            if (stat.is_word) begin
               if (!stat.pending) begin
                  cmd.op     = OP_REJECT;
                  cmd.status = ST_UNEXPECTED;
               end else if (stat.short_word) begin
                  cmd.op = OP_SHORT;
               end else begin
                  cmd.op   = OP_COMBINE;
                  state_in = S_ACC;
               end
            end else if (stat.is_bad_cmd || stat.pending) begin
               cmd.op     = OP_REJECT;
               cmd.status = ST_UNEXPECTED;
            end else if (stat.ended) begin
               cmd.op     = OP_REJECT;
               cmd.status = ST_PAST_END;
            end else if (stat.is_align) begin
               cmd.op = OP_ALIGN;
            end else if (!stat.width_ok) begin
               cmd.op     = OP_REJECT;
               cmd.status = ST_WIDTH;
            end else begin
               cmd.op   = OP_START;
               state_in = S_TAKE;
            end
         end
         S_TAKE: begin
            if (stat.enough) begin
               cmd.op   = OP_TAKE;
               state_in = S_ACC;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_ACC: begin
            cmd.op   = OP_ACC;
            state_in = stat.last_piece ? S_EMIT : S_TAKE;
         end
         S_EMIT: begin
            if (stat.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/bitstream_field_reader.sv
`default_nettype none

// Bitstream field reader: LSB-first reader over little-endian stream words.
// req_chan carries one word per handshake: a stream word (with its valid
// byte count) or a request: fixed field, vbr32, vbr64 or align to 32 bits.
// rsp_chan returns value, status and the count of unread bits still held.
// A request that runs short of held bits gives no word on rsp_chan; it waits
// for further stream words, which complete it (or end it, short at end).
// Steps: each accepted word is decoded; a rejected request, an align or a short
// final word then goes to the output register and the reader returns to idle.
// A fixed or vbr read runs the shared piece extract and accumulate steps, a vbr
// read once per piece; a stream word that completes a request combines its bits
// with the held ones and accumulates, then extracts any further vbr piece.
// Only one word is in work at a time.
// Results sit in an output register; when rsp_chan is stalled the reader may
// accept and work further words until it has one more result, which it holds,
// taking nothing further until the register frees on rsp_ready.
// Reset (synchronous, active high) empties the held word, drops any pending
// request, clears the end of stream flag and withdraws rsp_valid.
module bitstream_field_reader #(
   parameter int WORD_BITS = 64
) (
   input wire logic clock,
   input wire logic reset,
   bfr_req_if.sink   req_chan,
   bfr_rsp_if.source rsp_chan
);
   import bfr_pkg::*;

   dp_cmd_type  dp_cmd;
   dp_stat_type dp_stat;

   bfr_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (dp_stat),
      .cmd       (dp_cmd)
   );

   bfr_datapath #(
      .WORD_BITS (WORD_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (dp_cmd),
      .stat            (dp_stat),
      .req_command     (req_chan.command),
      .req_field_width (req_chan.field_width),
      .req_stream_word (req_chan.stream_word),
      .req_byte_count  (req_chan.byte_count),
      .rsp_valid       (rsp_chan.valid),
      .rsp_ready       (rsp_chan.ready),
      .rsp_value       (rsp_chan.value),
      .rsp_status      (rsp_chan.status),
      .rsp_bits_held   (rsp_chan.bits_held)
   );

endmodule

`default_nettype wire

// File: test/tb.sv
`timescale 1ns / 1ps

module tb;
   import bfr_pkg::*;

   localparam int          WORD_BITS  = 64;
   localparam int          WATCHDOG   = 2000;
   localparam int          RANDOM_RUN = 900;
   localparam command_type CMD_UNUSED = 3'd7;
   localparam word_type    ALL_ONES   = '1;

   typedef struct packed {
      command_type command;
      width_type   field_width;
      word_type    stream_word;
      bytes_type   byte_count;
   } field_req_type;

   typedef struct packed {
      value_type  value;
      status_type status;
      count_type  bits_held;
   } field_rsp_type;

   typedef struct packed {
      field_req_type q;
      logic          typed;
      field_rsp_type rsp;
   } stim_row_type;

   logic clock;
   logic reset;

   bfr_req_if req_chan ();
   bfr_rsp_if rsp_chan ();

   bitstream_field_reader #(.WORD_BITS(WORD_BITS)) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   field_rsp_type fields_due[$];
   int            failures = 0;
   bit            steady   = 1'b0;

   // bit reader state as the block should hold it
   word_type    held_word  = '0;
   int unsigned held_count = 0;
   command_type pend_kind  = NO_REQ;
   int unsigned pend_width = 0;
   value_type   part_value = '0;
   int unsigned part_pos   = 0;
   bit          stream_ended = 1'b0;

   function automatic word_type low_ones(input int unsigned n);
      return (n >= 64) ? ALL_ONES : ((64'd1 << n) - 64'd1);
   endfunction

   function automatic word_type pull_bits(input int unsigned n);
      word_type v;
      v = held_word & low_ones(n);
      held_word = (n >= 64) ? '0 : (held_word >> n);
      held_count -= n;
      return v;
   endfunction

   function automatic field_rsp_type answer(input value_type v, input status_type st);
      field_rsp_type r;
      r.value     = v;
      r.status    = st;
      r.bits_held = count_type'(held_count);
      return r;
   endfunction

   function automatic bit add_piece(input word_type piece, input int unsigned w);
      word_type data;
      data = piece & low_ones(w - 1);
      if (part_pos < 64) part_value |= data << part_pos;
      part_pos += w - 1;
      if (part_pos > 64) part_pos = 64;
      return piece[w-1] == 1'b0;
   endfunction

   function automatic field_rsp_type close_vbr(input command_type kind);
      value_type v;
      v = (kind == CMD_VBR32) ? {32'd0, part_value[31:0]} : part_value;
      pend_kind  = NO_REQ;
      pend_width = 0;
      part_value = '0;
      part_pos   = 0;
      return answer(v, ST_OK);
   endfunction

   function automatic bit continue_request(input command_type kind, input int unsigned w,
                                           output field_rsp_type r);
      if (kind == CMD_FIXED) begin
         if (held_count >= w) begin
            pend_kind  = NO_REQ;
            pend_width = 0;
            r = answer(pull_bits(w), ST_OK);
            return 1'b1;
         end
      end else begin
         while (held_count >= w) begin
            if (add_piece(pull_bits(w), w)) begin
               r = close_vbr(kind);
               return 1'b1;
            end
         end
      end
      pend_kind  = kind;
      pend_width = w;
      return 1'b0;
   endfunction

   function automatic bit decode_step(input field_req_type q, output field_rsp_type r);
      int unsigned w, nbytes, nbits, have, need;
      word_type    low, piece;
      command_type kind;
      w = q.field_width;
      if (q.command == CMD_WORD) begin
         kind = pend_kind;
         have = held_count;
         if (kind == NO_REQ) begin
            r = answer('0, ST_UNEXPECTED);
            return 1'b1;
         end
         nbytes = (q.byte_count > WORD_BITS / 8) ? WORD_BITS / 8 : q.byte_count;
         nbits = nbytes * 8;
         low = held_word & low_ones(have);
         held_word = q.stream_word & low_ones(nbits);
         held_count = nbits;
         need = pend_width - have;
         if (nbits < need) begin
            pend_kind    = NO_REQ;
            pend_width   = 0;
            part_value   = '0;
            part_pos     = 0;
            stream_ended = 1'b1;
            r = answer('0, ST_SHORT);
            return 1'b1;
         end
         piece = low | (pull_bits(need) << have);
         if (kind == CMD_FIXED) begin
            pend_kind  = NO_REQ;
            pend_width = 0;
            r = answer(piece, ST_OK);
            return 1'b1;
         end
         if (add_piece(piece, pend_width)) begin
            r = close_vbr(kind);
            return 1'b1;
         end
         return continue_request(kind, pend_width, r);
      end
      if (q.command > CMD_ALIGN || pend_kind != NO_REQ) begin
         r = answer('0, ST_UNEXPECTED);
         return 1'b1;
      end
      if (stream_ended) begin
         r = answer('0, ST_PAST_END);
         return 1'b1;
      end
      if (q.command == CMD_ALIGN) begin
         if (WORD_BITS > ALIGN_BITS && held_count >= ALIGN_BITS) begin
            held_word >>= held_count - ALIGN_BITS;
            held_count = ALIGN_BITS;
         end else begin
            held_word  = '0;
            held_count = 0;
         end
         r = answer('0, ST_OK);
         return 1'b1;
      end
      if (q.command == CMD_FIXED) begin
         if (w < 1 || w > WORD_BITS) begin
            r = answer('0, ST_WIDTH);
            return 1'b1;
         end
      end else begin
         if (w < 2 || w > VBR_MAX_WIDTH) begin
            r = answer('0, ST_WIDTH);
            return 1'b1;
         end
         part_value = '0;
         part_pos   = 0;
      end
      return continue_request(q.command, w, r);
   endfunction

   function automatic stim_row_type plain_row(input command_type c, input int unsigned w,
                                              input word_type word,
                                              input int unsigned nbytes);
      stim_row_type s;
      s.q     = '{command: c, field_width: width_type'(w), stream_word: word,
                  byte_count: bytes_type'(nbytes)};
      s.typed = 1'b0;
      s.rsp   = '0;
      return s;
   endfunction

   function automatic stim_row_type known_row(input command_type c, input int unsigned w,
                                              input word_type word,
                                              input int unsigned nbytes,
                                              input value_type v, input status_type st,
                                              input int unsigned held);
      stim_row_type s;
      s = plain_row(c, w, word, nbytes);
      s.typed = 1'b1;
      s.rsp   = '{value: v, status: st, bits_held: count_type'(held)};
      return s;
   endfunction

   function automatic int unsigned idle_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (steady || roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   task automatic send_item(input field_req_type q, input bit typed,
                            input field_rsp_type known);
      field_rsp_type r;
      int unsigned gap;
      gap = idle_gap();
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.command     <= q.command;
      req_chan.field_width <= q.field_width;
      req_chan.stream_word <= q.stream_word;
      req_chan.byte_count  <= q.byte_count;
      do @(posedge clock); while (!req_chan.ready);
      if (decode_step(q, r)) fields_due = {fields_due, typed ? known : r};
   endtask

   task automatic drain_results();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (fields_due.size() != 0);
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      int unsigned gap;
      forever begin
         gap = idle_gap();
         if (gap != 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      field_rsp_type want;
      if (rsp_chan.valid && rsp_chan.ready) begin
         if (fields_due.size() == 0) begin
            $error("unexpected word: value %h status %0d bits_held %0d",
                   rsp_chan.value, rsp_chan.status, rsp_chan.bits_held);
            failures++;
         end else begin
            want = fields_due.pop_front();
            if (rsp_chan.value !== want.value) begin
               $error("value: expected %h, actual %h", want.value, rsp_chan.value);
               failures++;
            end
            if (rsp_chan.status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_chan.status);
               failures++;
            end
            if (rsp_chan.bits_held !== want.bits_held) begin
               $error("bits_held: expected %0d, actual %0d", want.bits_held,
                      rsp_chan.bits_held);
               failures++;
            end
         end
      end
   end

   initial begin
      int unsigned quiet;
      quiet = 0;
      while (quiet < WATCHDOG) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("Some tests failed");
      $finish;
   end

   initial begin
      field_req_type q;
      stim_row_type  opening_rows[$];
      stim_row_type  closing_rows[$];
      int unsigned   roll, need;

      reset                <= 1'b1;
      req_chan.valid       <= 1'b0;
      req_chan.command     <= CMD_WORD;
      req_chan.field_width <= '0;
      req_chan.stream_word <= '0;
      req_chan.byte_count  <= '0;

      opening_rows = '{
         known_row(CMD_WORD, 0, ALL_ONES, 8, '0, ST_UNEXPECTED, 0),
         known_row(CMD_ALIGN, 0, '0, 0, '0, ST_OK, 0),
         known_row(CMD_FIXED, 0, '0, 0, '0, ST_WIDTH, 0),
         known_row(CMD_FIXED, 127, ALL_ONES, 15, '0, ST_WIDTH, 0),
         known_row(CMD_VBR32, 1, '0, 0, '0, ST_WIDTH, 0),
         known_row(CMD_VBR64, 33, '0, 0, '0, ST_WIDTH, 0),
         known_row(CMD_UNUSED, 0, '0, 0, '0, ST_UNEXPECTED, 0),
         plain_row(CMD_FIXED, 64, '0, 0),
         known_row(CMD_FIXED, 8, '0, 0, '0, ST_UNEXPECTED, 0),
         known_row(CMD_WORD, 0, ALL_ONES, 8, ALL_ONES, ST_OK, 0),
         plain_row(CMD_FIXED, 1, '0, 0),
         known_row(CMD_WORD, 0, 64'h0123_4567_89AB_CDEF, 15, 64'd1, ST_OK, 63),
         plain_row(CMD_FIXED, 64, '0, 0),
         plain_row(CMD_WORD, 0, 64'hFFFF_FFFF_FFFF_FF80, 1),
         plain_row(CMD_FIXED, 8, '0, 0),
         plain_row(CMD_WORD, 0, 64'hDEAD_BEEF_0BAD_F00D, 8),
         known_row(CMD_ALIGN, 0, '0, 0, '0, ST_OK, 32),
         known_row(CMD_ALIGN, 0, '0, 0, '0, ST_OK, 32),
         plain_row(CMD_FIXED, 5, '0, 0),
         known_row(CMD_ALIGN, 0, '0, 0, '0, ST_OK, 0),
         plain_row(CMD_VBR64, 2, '0, 0),
         plain_row(CMD_WORD, 0, ALL_ONES, 8),
         plain_row(CMD_WORD, 0, ALL_ONES, 8),
         known_row(CMD_WORD, 0, '0, 1, ALL_ONES, ST_OK, 6),
         plain_row(CMD_VBR32, 32, '0, 0),
         plain_row(CMD_WORD, 0, ALL_ONES, 8),
         plain_row(CMD_WORD, 0, '0, 8)
      };

      // a short final word ends the stream for good, so it comes last
      closing_rows = '{
         plain_row(CMD_ALIGN, 0, '0, 0),
         plain_row(CMD_FIXED, 64, '0, 0),
         known_row(CMD_WORD, 0, ALL_ONES, 3, '0, ST_SHORT, 24),
         known_row(CMD_FIXED, 8, ALL_ONES, 8, '0, ST_PAST_END, 24),
         known_row(CMD_VBR64, 4, '0, 0, '0, ST_PAST_END, 24),
         known_row(CMD_ALIGN, 0, '0, 0, '0, ST_PAST_END, 24),
         known_row(CMD_FIXED, 0, '0, 0, '0, ST_PAST_END, 24),
         known_row(CMD_UNUSED, 0, '0, 0, '0, ST_UNEXPECTED, 24),
         known_row(CMD_WORD, 0, ALL_ONES, 8, '0, ST_UNEXPECTED, 24)
      };

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (opening_rows[i])
         send_item(opening_rows[i].q, opening_rows[i].typed, opening_rows[i].rsp);
      drain_results();

      for (int n = 0; n < RANDOM_RUN; n++) begin
         if (n % 64 == 0) steady = ($urandom_range(0, 4) == 0);
         roll          = $urandom_range(0, 99);
         q.stream_word = {$urandom, $urandom};
         q.byte_count  = bytes_type'($urandom_range(0, 15));
         q.field_width = width_type'($urandom_range(0, 127));
         if (pend_kind != NO_REQ) begin
            if (roll < 92) begin
               // enough bytes to serve the waiting piece, so the stream never ends here
               need = pend_width - held_count;
               q.command = CMD_WORD;
               if (roll < 8)
                  q.byte_count = bytes_type'($urandom_range(9, 15));
               else
                  q.byte_count = bytes_type'($urandom_range((need + 7) / 8, WORD_BITS / 8));
               if ($urandom_range(0, 15) == 0) q.stream_word = ALL_ONES;
               else if ($urandom_range(0, 15) == 0) q.stream_word = '0;
            end else begin
               q.command = command_type'($urandom_range(CMD_FIXED, CMD_UNUSED));
            end
         end else if (roll < 45) begin
            q.command = CMD_FIXED;
            if ($urandom_range(0, 3) == 0)
               q.field_width = width_type'($urandom_range(1, WORD_BITS));
            else
               q.field_width = width_type'($urandom_range(1, 16));
         end else if (roll < 75) begin
            q.command = $urandom_range(0, 1) ? CMD_VBR32 : CMD_VBR64;
            if ($urandom_range(0, 3) == 0)
               q.field_width = width_type'($urandom_range(2, VBR_MAX_WIDTH));
            else
               q.field_width = width_type'($urandom_range(2, 8));
         end else if (roll < 83) begin
            q.command = CMD_ALIGN;
         end else if (roll < 90) begin
            q.command = command_type'($urandom_range(CMD_FIXED, CMD_VBR64));
            if (q.command == CMD_FIXED)
               q.field_width = $urandom_range(0, 1) ? width_type'(0)
                             : width_type'($urandom_range(WORD_BITS + 1, 127));
            else
               q.field_width = $urandom_range(0, 1) ? width_type'($urandom_range(0, 1))
                             : width_type'($urandom_range(VBR_MAX_WIDTH + 1, 127));
         end else begin
            q.command = $urandom_range(0, 1) ? CMD_WORD
                      : command_type'($urandom_range(CMD_ALIGN + 1, CMD_UNUSED));
         end
         send_item(q, 1'b0, '0);
         if (n % 150 == 149) drain_results();
      end

      steady = 1'b0;
      while (pend_kind != NO_REQ) begin
         q.command     = CMD_WORD;
         q.field_width = '0;
         q.stream_word = {$urandom, $urandom};
         q.byte_count  = bytes_type'(WORD_BITS / 8);
         send_item(q, 1'b0, '0);
      end
      drain_results();

      foreach (closing_rows[i])
         send_item(closing_rows[i].q, closing_rows[i].typed, closing_rows[i].rsp);
      drain_results();
      repeat (100) @(posedge clock);

      if (failures == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
